/* sv/crcflr_pkg.sv */
// ----------------------------------------------------------------------------
// crcflr_pkg
// Shared types, codes and the CRC-16/CCITT-FALSE byte update for the
// CRC-checked line frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package crcflr_pkg;

  // Default line buffer size in bytes, including the leading '$'
  localparam int LINE_BYTES_DEF = 128;

  // Depth of the request queue between the parts of the block and of the result queue
  localparam int FIFO_DEPTH = 2;

  // CRC-16/CCITT-FALSE
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // Characters of interest
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_L      = 8'h4C;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_B      = 8'h42;
  localparam logic [7:0] CH_COMMA  = 8'h2C;

  // Result status codes
  typedef enum logic [1:0] {
    ST_IGNORED = 2'd0,
    ST_FRAME   = 2'd1,
    ST_ERROR   = 2'd2
  } status_t;

  // Sticky error codes
  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_LENGTH = 2'd1,
    ERR_SYNTAX = 2'd2,
    ERR_CRC    = 2'd3
  } err_t;

  // Classified received byte, passed from the front part to the back part
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       is_lf;
    logic       is_dollar;
    logic       is_star;
    logic       is_cr;
    logic       hex_ok;
    logic [3:0] hex_val;
    logic [3:0] pfx_hit;   // bit k: byte equals character k of "LAB,"
  } class_t;

  // Advance the CRC by one byte, MSB first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
                                             input logic [7:0]  b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* sv/crcflr_fifo.sv */
// ----------------------------------------------------------------------------
// crcflr_fifo
// Small flip-flop request queue with full and empty flags.
// ----------------------------------------------------------------------------
`default_nettype none

module crcflr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r,  count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_FULL);
  assign empty   = (count_r == '0);
  assign rdata   = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed request
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

/* sv/crcflr_front.sv */
// ----------------------------------------------------------------------------
// crcflr_front
// Classifies each received byte: framing characters, hex digit value and
// matches against the "LAB," prefix.
// ----------------------------------------------------------------------------
`default_nettype none

module crcflr_front (
  input  wire logic [7:0]          rx_byte,
  output crcflr_pkg::class_t       cls
);

  import crcflr_pkg::*;

  logic       is_num, is_upper, is_lower;
  logic [7:0] num_val, upper_val, lower_val;

  // Decode hex digit ranges
  assign is_num    = (rx_byte >= 8'h30) && (rx_byte <= 8'h39);
  assign is_upper  = (rx_byte >= 8'h41) && (rx_byte <= 8'h46);
  assign is_lower  = (rx_byte >= 8'h61) && (rx_byte <= 8'h66);
  assign num_val   = rx_byte - 8'h30;
  assign upper_val = rx_byte - 8'h37;
  assign lower_val = rx_byte - 8'h57;

  always_comb begin
    cls.rx_byte   = rx_byte;
    cls.is_lf     = (rx_byte == CH_LF);
    cls.is_dollar = (rx_byte == CH_DOLLAR);
    cls.is_star   = (rx_byte == CH_STAR);
    cls.is_cr     = (rx_byte == CH_CR);
    cls.hex_ok    = is_num || is_upper || is_lower;
    priority if (is_num) begin
      cls.hex_val = num_val[3:0];
    end else if (is_upper) begin
      cls.hex_val = upper_val[3:0];
    end else begin
      cls.hex_val = lower_val[3:0];
    end
    cls.pfx_hit = {rx_byte == CH_COMMA, rx_byte == CH_B,
                   rx_byte == CH_A,     rx_byte == CH_L};
  end

endmodule

`default_nettype wire

/* sv/crcflr_back.sv */
// ----------------------------------------------------------------------------
// crcflr_back
// Runs the frame state: CRC accumulation, star capture, digit parsing, line
// length limit and the end-of-line check. Produces one result per byte.
// ----------------------------------------------------------------------------
`default_nettype none

module crcflr_back #(
  parameter int LINE_BYTES = crcflr_pkg::LINE_BYTES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_data,
  input  wire logic                          req_empty,
  input  wire crcflr_pkg::class_t            req,
  output logic                               req_pop,
  input  wire logic                          res_full,
  output logic                               res_push,
  output crcflr_pkg::status_t                res_status,
  output crcflr_pkg::err_t                   res_err,
  output logic                               res_crc_ok,
  output logic [$clog2(LINE_BYTES)-1:0]      res_end
);

  import crcflr_pkg::*;

  localparam int CW = $clog2(LINE_BYTES);
  localparam logic [CW-1:0] CNT_MAX = CW'(LINE_BYTES - 1);
  localparam logic [CW-1:0] LEN_MIN = CW'(3);
  localparam logic [CW-1:0] LEN_PFX = CW'(5);
  localparam logic [CW-1:0] POS_PFX = CW'(4);

  logic          dev_mode_r;
  logic          in_frame_r,  in_frame_nxt;
  logic          skip_r,      skip_nxt;
  logic [CW-1:0] cnt_r,       cnt_nxt;
  logic [15:0]   crc_r,       crc_nxt;
  logic [15:0]   crc_star_r,  crc_star_nxt;
  logic [CW-1:0] star_pos_r,  star_pos_nxt;
  logic [2:0]    after_r,     after_nxt;
  logic [15:0]   rcv_crc_r,   rcv_crc_nxt;
  logic          dig_ok_r,    dig_ok_nxt;
  logic          last_cr_r,   last_cr_nxt;
  logic          pfx_ok_r,    pfx_ok_nxt;
  err_t          err_r,       err_nxt;
  logic          crc_ok_r,    crc_ok_nxt;

  logic          fire;
  logic          trim;
  logic [CW-1:0] len;
  logic [2:0]    after_eff;
  logic [CW-1:0] pos_m1;
  logic [15:0]   crc_upd;
  status_t       status;
  logic [CW-1:0] end_pos;

  assign fire     = !req_empty && !res_full;
  assign req_pop  = fire;
  assign res_push = fire;
  assign crc_upd  = crc16_byte(crc_r, req.rx_byte);
  assign pos_m1   = cnt_r - 1'b1;

  // Trim a trailing CR in device mode
  assign trim      = dev_mode_r && (cnt_r != '0) && last_cr_r;
  assign len       = cnt_r - CW'(trim);
  assign after_eff = (trim && (star_pos_r != '0) && (after_r != '0)) ?
                     after_r - 1'b1 : after_r;

  // Next state and result for one byte
  always_comb begin
    in_frame_nxt = in_frame_r;
    skip_nxt     = skip_r;
    cnt_nxt      = cnt_r;
    crc_nxt      = crc_r;
    crc_star_nxt = crc_star_r;
    star_pos_nxt = star_pos_r;
    after_nxt    = after_r;
    rcv_crc_nxt  = rcv_crc_r;
    dig_ok_nxt   = dig_ok_r;
    last_cr_nxt  = last_cr_r;
    pfx_ok_nxt   = pfx_ok_r;
    err_nxt      = err_r;
    crc_ok_nxt   = crc_ok_r;
    status       = ST_IGNORED;
    end_pos      = '0;

    if (!in_frame_r) begin
      // Outside a frame: wait for '$', skipping lines in device mode
      if (req.is_lf) begin
        cnt_nxt  = '0;
        skip_nxt = 1'b0;
      end else if (!skip_r) begin
        if (req.is_dollar) begin
          in_frame_nxt = 1'b1;
          cnt_nxt      = CW'(1);
          crc_nxt      = CRC_INIT;
          crc_star_nxt = CRC_INIT;
          star_pos_nxt = '0;
          after_nxt    = '0;
          rcv_crc_nxt  = '0;
          dig_ok_nxt   = 1'b1;
          last_cr_nxt  = 1'b0;
          pfx_ok_nxt   = 1'b1;
          crc_ok_nxt   = 1'b0;
          err_nxt      = ERR_NONE;
        end else if (dev_mode_r) begin
          skip_nxt = 1'b1;
        end
      end
    end else if (req.is_lf) begin
      // End of line: check the frame
      in_frame_nxt = 1'b0;
      cnt_nxt      = '0;
      if (len < LEN_MIN) begin
        status = ST_IGNORED;
      end else if (star_pos_r == '0) begin
        if (dev_mode_r) begin
          if ((len >= LEN_PFX) && pfx_ok_r) begin
            status  = ST_FRAME;
            end_pos = len;
          end else begin
            status  = ST_ERROR;
            err_nxt = ERR_SYNTAX;
          end
        end
      end else if ((after_eff < 3'd4) || !dig_ok_r) begin
        status  = ST_ERROR;
        err_nxt = ERR_SYNTAX;
      end else if (rcv_crc_r == crc_star_r) begin
        crc_ok_nxt = 1'b1;
        status     = ST_FRAME;
        end_pos    = star_pos_r;
      end else begin
        crc_ok_nxt = 1'b0;
        status     = ST_ERROR;
        err_nxt    = ERR_CRC;
      end
    end else if (cnt_r >= CNT_MAX) begin
      // Line too long: drop the frame
      in_frame_nxt = 1'b0;
      cnt_nxt      = '0;
      err_nxt      = ERR_LENGTH;
      status       = ST_ERROR;
      if (dev_mode_r) begin
        skip_nxt = 1'b1;
      end
    end else begin
      // Frame body byte
      if ((cnt_r != '0) && (cnt_r <= POS_PFX) && !req.pfx_hit[pos_m1[1:0]]) begin
        pfx_ok_nxt = 1'b0;
      end
      if (req.is_star) begin
        crc_star_nxt = crc_r;
        star_pos_nxt = cnt_r;
        after_nxt    = '0;
        rcv_crc_nxt  = '0;
        dig_ok_nxt   = 1'b1;
      end else if (star_pos_r != '0) begin
        if (after_r < 3'd4) begin
          if (!req.hex_ok) begin
            dig_ok_nxt = 1'b0;
          end else begin
            rcv_crc_nxt = {rcv_crc_r[11:0], req.hex_val};
          end
        end
        if (after_r != 3'd7) begin
          after_nxt = after_r + 1'b1;
        end
      end
      crc_nxt     = crc_upd;
      last_cr_nxt = req.is_cr;
      cnt_nxt     = cnt_r + 1'b1;
    end
  end

  assign res_status = status;
  assign res_err    = err_nxt;
  assign res_crc_ok = crc_ok_nxt;
  assign res_end    = end_pos;

  // Hold the mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_mode_r <= 1'b0;
    end else if (cfg_we) begin
      dev_mode_r <= cfg_data;
    end
  end

  // Advance frame state on each consumed request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      skip_r     <= 1'b0;
      cnt_r      <= '0;
      crc_r      <= CRC_INIT;
      crc_star_r <= CRC_INIT;
      star_pos_r <= '0;
      after_r    <= '0;
      rcv_crc_r  <= '0;
      dig_ok_r   <= 1'b1;
      last_cr_r  <= 1'b0;
      pfx_ok_r   <= 1'b1;
      err_r      <= ERR_NONE;
      crc_ok_r   <= 1'b0;
    end else if (fire) begin
      in_frame_r <= in_frame_nxt;
      skip_r     <= skip_nxt;
      cnt_r      <= cnt_nxt;
      crc_r      <= crc_nxt;
      crc_star_r <= crc_star_nxt;
      star_pos_r <= star_pos_nxt;
      after_r    <= after_nxt;
      rcv_crc_r  <= rcv_crc_nxt;
      dig_ok_r   <= dig_ok_nxt;
      last_cr_r  <= last_cr_nxt;
      pfx_ok_r   <= pfx_ok_nxt;
      err_r      <= err_nxt;
      crc_ok_r   <= crc_ok_nxt;
    end
  end

endmodule

`default_nettype wire

/* sv/crc_framed_line_receiver_unit.sv */
// ----------------------------------------------------------------------------
// crc_framed_line_receiver_unit
// Line frame receiver with CRC-16/CCITT-FALSE check on '$' ... '*hhhh' lines.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue side: drive in_rx_byte and raise in_push; the byte is taken
//   on a clock edge where in_full is low. One result is made for every byte.
//   Result queue side: while out_empty is low the oldest result sits on
//   out_status, out_error_code, out_crc_ok and out_frame_end; raise out_pop
//   to take it.
//   Configuration: cfg_data sets device mode on an edge with cfg_valid high
//   (cfg_ready is always high). Write it only while no bytes are in flight.
// Timing:
//   A byte is classified and queued on acceptance, then processed by the frame
//   state, and its result is written to the result queue, whose head drives
//   the result ports. One byte per cycle is sustained while results are
//   popped; the combinational CRC byte update and frame state register set
//   that rate.
// Reset and stalls:
//   rst_n clears both queues, the frame state and device mode. When results
//   are not popped the result queue fills, the frame state stops, and then
//   the input queue fills and in_full rises; nothing is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module crc_framed_line_receiver_unit #(
  parameter int LINE_BYTES = crcflr_pkg::LINE_BYTES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_push,
  input  wire logic [7:0]                    in_rx_byte,
  output logic                               in_full,
  output logic                               out_empty,
  input  wire logic                          out_pop,
  output logic [1:0]                         out_status,
  output logic [1:0]                         out_error_code,
  output logic                               out_crc_ok,
  output logic [$clog2(LINE_BYTES)-1:0]      out_frame_end,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic                          cfg_data
);

  import crcflr_pkg::*;

  localparam int CW = $clog2(LINE_BYTES);
  localparam int CLS_W = $bits(class_t);
  localparam int RES_W = 5 + CW;

  class_t            cls_in;
  class_t            cls_out;
  logic [CLS_W-1:0]  cls_rdata;
  logic              cls_empty;
  logic              cls_pop;

  status_t           res_status;
  err_t              res_err;
  logic              res_crc_ok;
  logic [CW-1:0]     res_end;
  logic              res_push;
  logic              res_full;
  logic [RES_W-1:0]  res_rdata;

  assign cfg_ready = 1'b1;

  // Classify incoming bytes
  crcflr_front u_front (
    .rx_byte (in_rx_byte),
    .cls     (cls_in)
  );

  // Queue classified requests
  crcflr_fifo #(
    .WIDTH (CLS_W),
    .DEPTH (FIFO_DEPTH)
  ) u_req_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (cls_in),
    .full  (in_full),
    .pop   (cls_pop),
    .rdata (cls_rdata),
    .empty (cls_empty)
  );

  assign cls_out = class_t'(cls_rdata);

  // Run frame state
  crcflr_back #(
    .LINE_BYTES (LINE_BYTES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .req_empty  (cls_empty),
    .req        (cls_out),
    .req_pop    (cls_pop),
    .res_full   (res_full),
    .res_push   (res_push),
    .res_status (res_status),
    .res_err    (res_err),
    .res_crc_ok (res_crc_ok),
    .res_end    (res_end)
  );

  // Queue results for the receiver
  crcflr_fifo #(
    .WIDTH (RES_W),
    .DEPTH (FIFO_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata ({res_status, res_err, res_crc_ok, res_end}),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_rdata),
    .empty (out_empty)
  );

  assign out_status     = res_rdata[RES_W-1 -: 2];
  assign out_error_code = res_rdata[RES_W-3 -: 2];
  assign out_crc_ok     = res_rdata[CW];
  assign out_frame_end  = res_rdata[CW-1:0];

endmodule

`default_nettype wire
